// ----- src/cse_pkg.sv -----
package cse_pkg;

    localparam int KEY_W    = 8;
    localparam int REMAIN_W = 11;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    // result beat, lowest field last
    typedef struct packed
    {
        logic [REMAIN_W-1:0] remaining;
        logic                rejected;
        logic                found;
        logic [KEY_W-1:0]    sorted_key;
    } result_t;

    localparam int OUT_TDATA_W = ((KEY_W + REMAIN_W + 7) / 8) * 8;

endpackage

// ----- src/counting_sort_engine_unit.sv -----
// Channel  Dir  Signals                     Beat contents (lowest bit up)
// -------  ---  --------------------------  -----------------------------------------
// s_axis   in   tvalid tready tdata tuser   tdata: key_in[7:0]; tuser: opcode
// m_axis   out  tvalid tready tdata tuser   tdata: sorted_key[7:0], remaining[18:8],
//                                                  zero pad; tuser: found, rejected
//
// A load reads its bucket, then writes it back incremented.
// A pop scans upward from the scan pointer to the first non-empty bucket; the scan walks
// one bucket per cycle through the single read port of the bucket memory.
// A rejected load or a pop on an empty store is answered from idle, without a bucket read.
// Reset clears the histogram at once through one valid bit per bucket; no clearing pass.
// Stalls: a new beat is taken only while the result register is free or being drained.
module counting_sort_engine_unit
#(
    parameter int KEY_RANGE = 256,
    parameter int MAX_ITEMS = 1024
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [cse_pkg::KEY_W-1:0]            s_axis_tdata,   // key_in
    input  logic                                 s_axis_tuser,   // opcode
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [cse_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // sorted_key, remaining, pad
    output logic [1:0]                           m_axis_tuser    // found, rejected
);

    // keys above 255 cannot arrive, so at most 256 buckets exist
    localparam int BUCKETS = (KEY_RANGE < 256) ? KEY_RANGE : 256;
    localparam int IDX_W   = $clog2(BUCKETS);
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN
    } state_t;

    state_t                 state_reg;
    logic [IDX_W-1:0]       idx_reg;        // bucket under work
    logic [IDX_W-1:0]       scan_ptr_reg;   // lowest bucket that may be non-empty
    logic [CNT_W-1:0]       held_reg;
    logic [BUCKETS-1:0]     valid_reg;      // bucket written since reset
    logic                   rd_valid_reg;
    logic [CNT_W-1:0]       rd_data_reg;
    logic                   out_valid_reg;
    cse_pkg::result_t       out_reg;

    logic [CNT_W-1:0]       bucket_mem [BUCKETS];

    logic                   accept;
    logic                   key_bad;
    logic                   full;
    logic [IDX_W-1:0]       key_idx;
    logic [IDX_W-1:0]       rd_addr;
    logic [CNT_W-1:0]       cnt;
    logic                   hit;
    logic                   last_bucket;
    logic                   wr_en;
    logic [CNT_W-1:0]       wr_data;
    cse_pkg::opcode_t       op;

    assign op            = cse_pkg::opcode_t'(s_axis_tuser);
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign key_idx       = s_axis_tdata[IDX_W-1:0];
    assign key_bad       = {1'b0, s_axis_tdata} >= 9'(BUCKETS);
    assign full          = held_reg >= CNT_W'(MAX_ITEMS);

    // never-written buckets read as empty
    assign cnt         = rd_valid_reg ? rd_data_reg : '0;
    assign hit         = (cnt != '0);
    assign last_bucket = (idx_reg == IDX_W'(BUCKETS - 1));

    // scan reads the next bucket ahead; wasted when the current one hits
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: rd_addr = (op == cse_pkg::OP_POP) ? scan_ptr_reg : key_idx;
            ST_SCAN: rd_addr = idx_reg + 1'b1;
            default: rd_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = cnt;
        unique case (state_reg)
            ST_LOAD:
            begin
                wr_en   = 1'b1;
                wr_data = cnt + 1'b1;
            end
            ST_SCAN:
            begin
                wr_en   = hit;
                wr_data = cnt - 1'b1;
            end
            default: ;
        endcase
    end

    // bucket memory, one write and one registered read per cycle; writes and
    // reads of the same item never land on the same edge, so no bypass is needed
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bucket_mem[idx_reg] <= wr_data;
        end
        rd_data_reg <= bucket_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            scan_ptr_reg  <= '0;
            held_reg      <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        out_reg <= '0;
                        if (op == cse_pkg::OP_LOAD)
                        begin
                            if (key_bad || full)
                            begin
                                out_reg.rejected  <= 1'b1;
                                out_reg.remaining <= cse_pkg::REMAIN_W'(held_reg);
                                out_valid_reg     <= 1'b1;
                            end
                            else
                            begin
                                idx_reg   <= key_idx;
                                state_reg <= ST_LOAD;
                            end
                        end
                        else if (held_reg == '0)
                        begin
                            // pop on empty store
                            out_reg.remaining <= cse_pkg::REMAIN_W'(held_reg);
                            out_valid_reg     <= 1'b1;
                        end
                        else
                        begin
                            idx_reg   <= scan_ptr_reg;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_LOAD:
                begin
                    held_reg <= held_reg + 1'b1;
                    if (idx_reg < scan_ptr_reg)
                    begin
                        scan_ptr_reg <= idx_reg;
                    end
                    out_reg.remaining <= cse_pkg::REMAIN_W'(held_reg + 1'b1);
                    out_valid_reg     <= 1'b1;
                    state_reg         <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    if (hit)
                    begin
                        held_reg           <= held_reg - 1'b1;
                        scan_ptr_reg       <= idx_reg;
                        out_reg.sorted_key <= cse_pkg::KEY_W'(idx_reg);
                        out_reg.found      <= 1'b1;
                        out_reg.remaining  <= cse_pkg::REMAIN_W'(held_reg - 1'b1);
                        out_valid_reg      <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                    else if (last_bucket)
                    begin
                        out_reg.remaining <= cse_pkg::REMAIN_W'(held_reg);
                        out_valid_reg     <= 1'b1;
                        state_reg         <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = cse_pkg::OUT_TDATA_W'({out_reg.remaining, out_reg.sorted_key});
    assign m_axis_tuser  = {out_reg.rejected, out_reg.found};

endmodule

// ----- src/cse_checker.sv -----
module cse_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [cse_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic [1:0]                           m_axis_tuser
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

    // a full result register blocks the input unless it is being drained
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input ready while result waits");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found and rejected both set");

    // only a hit carries a key
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[cse_pkg::KEY_W-1:0] == '0))
    else $error("key shown without a hit");

endmodule

bind counting_sort_engine_unit cse_checker u_cse_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
